FILE: rtl/core/kocrt_pkg.sv
package kocrt_pkg;

   localparam int KEY_PORT_W = 64;
   localparam int COUNT_W    = 32;
   localparam int RANK_W     = 9;

   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
   localparam logic [RANK_W-1:0]  RANK_MAX  = '1;

   typedef enum logic [1:0] {
      REQ_ADD   = 2'd0,
      REQ_COUNT = 2'd1,
      REQ_RANK  = 2'd2,
      REQ_NONE  = 2'd3
   } req_code_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SCAN = 4'b0010,
      ST_RANK = 4'b0100,
      ST_RESP = 4'b1000
   } state_type;

endpackage

FILE: rtl/core/key_occurrence_count_rank_table_core.sv
// Key occurrence count table with rank query.
// Request channel: drive req_type and req_name_key and raise start while busy
// is low; the request is taken at that clock edge. Codes: add one occurrence,
// query count, query rank, none. Only the low KEY_BITS bits of the key take part.
// Response channel: rsp_strobe is high for exactly one cycle with rsp_found,
// rsp_occurrences, rsp_rank_value and rsp_status valid in that cycle. The
// receiver cannot stall; the response is simply presented once.
// Keys and counts live in two synchronous memories, each with one read and one
// write port and a registered read. An add, count or rank request scans
// entries 0 to N-1 (N = entries in use), one read per cycle, until the key
// matches; a rank request on a present key then scans all N counts again.
// busy stays high from the accepted request until the cycle the response
// strobe rises, so the next request can be taken at the edge that ends the
// strobe cycle.
// Reset clears the fill count, so the table reads as empty; the memories keep
// their contents but entries beyond the fill count are never used.
module key_occurrence_count_rank_table_core #(
   parameter int TABLE_ENTRIES = 256,
   parameter int KEY_BITS      = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [1:0]                          req_type,
   input  logic [kocrt_pkg::KEY_PORT_W-1:0]    req_name_key,
   output logic                                rsp_strobe,
   output logic                                rsp_found,
   output logic [kocrt_pkg::COUNT_W-1:0]       rsp_occurrences,
   output logic [kocrt_pkg::RANK_W-1:0]        rsp_rank_value,
   output logic                                rsp_status
);

   localparam int IDX_W  = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
   localparam logic [USED_W-1:0] FULL_COUNT = USED_W'(TABLE_ENTRIES);

   logic [KEY_BITS-1:0]             key_mem [TABLE_ENTRIES];
   logic [kocrt_pkg::COUNT_W-1:0]   cnt_mem [TABLE_ENTRIES];

   kocrt_pkg::state_type            state_ff, state_in;
   logic [1:0]                      req_ff, req_in;
   logic [KEY_BITS-1:0]             key_ff, key_in;
   logic [USED_W-1:0]               used_ff, used_in;
   logic [USED_W-1:0]               issue_ff, issue_in;
   logic                            rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]                rd_idx_ff;
   logic [KEY_BITS-1:0]             key_rd_ff;
   logic [kocrt_pkg::COUNT_W-1:0]   cnt_rd_ff;
   logic [IDX_W-1:0]                hit_idx_ff, hit_idx_in;
   logic [kocrt_pkg::COUNT_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [kocrt_pkg::RANK_W-1:0]    rank_ff, rank_in;
   logic                            matched_ff, matched_in;

   logic                            rsp_strobe_ff, rsp_strobe_in;
   logic                            rsp_found_ff, rsp_found_in;
   logic [kocrt_pkg::COUNT_W-1:0]   rsp_occ_ff, rsp_occ_in;
   logic [kocrt_pkg::RANK_W-1:0]    rsp_rank_ff, rsp_rank_in;
   logic                            rsp_status_ff, rsp_status_in;

   logic [IDX_W-1:0]                rd_addr;
   logic                            cnt_wr_en, key_wr_en;
   logic [IDX_W-1:0]                wr_addr;
   logic [kocrt_pkg::COUNT_W-1:0]   cnt_wr_data;
   logic                            hit, scan_over;
   logic [kocrt_pkg::COUNT_W-1:0]   cnt_inc;

   assign rd_addr   = issue_ff[IDX_W-1:0];
   assign hit       = rd_vld_ff && (key_rd_ff == key_ff);
   assign scan_over = !rd_vld_ff && (issue_ff >= used_ff);
   assign cnt_inc   = (hit_cnt_ff == kocrt_pkg::COUNT_MAX) ? hit_cnt_ff
                                                           : hit_cnt_ff + 1'b1;

   always_ff @(posedge clock) begin
      key_rd_ff <= key_mem[rd_addr];
      cnt_rd_ff <= cnt_mem[rd_addr];
      rd_idx_ff <= rd_addr;
      if (key_wr_en) begin
         key_mem[wr_addr] <= key_ff;
      end
      if (cnt_wr_en) begin
         cnt_mem[wr_addr] <= cnt_wr_data;
      end
   end

   always_comb begin
      state_in      = state_ff;
      req_in        = req_ff;
      key_in        = key_ff;
      used_in       = used_ff;
      issue_in      = issue_ff;
      rd_vld_in     = 1'b0;
      hit_idx_in    = hit_idx_ff;
      hit_cnt_in    = hit_cnt_ff;
      rank_in       = rank_ff;
      rsp_strobe_in = 1'b0;
      rsp_found_in  = rsp_found_ff;
      rsp_occ_in    = rsp_occ_ff;
      rsp_rank_in   = rsp_rank_ff;
      rsp_status_in = rsp_status_ff;
      key_wr_en     = 1'b0;
      cnt_wr_en     = 1'b0;
      wr_addr       = hit_idx_ff;
      cnt_wr_data   = cnt_inc;

      case (state_ff)
         kocrt_pkg::ST_IDLE: begin
            if (start) begin
               req_in   = req_type;
               key_in   = req_name_key[KEY_BITS-1:0];
               issue_in = '0;
               if (req_type == kocrt_pkg::REQ_NONE) begin
                  state_in = kocrt_pkg::ST_RESP;
               end else begin
                  state_in = kocrt_pkg::ST_SCAN;
               end
            end
         end
         kocrt_pkg::ST_SCAN: begin
            if (hit) begin
               hit_idx_in = rd_idx_ff;
               hit_cnt_in = cnt_rd_ff;
               if (req_ff == kocrt_pkg::REQ_RANK) begin
                  // rescan all counts against this one
                  issue_in = '0;
                  rank_in  = kocrt_pkg::RANK_W'(1);
                  state_in = kocrt_pkg::ST_RANK;
               end else begin
                  state_in = kocrt_pkg::ST_RESP;
               end
            end else if (scan_over) begin
               state_in = kocrt_pkg::ST_RESP;
            end else if (issue_ff < used_ff) begin
               issue_in  = issue_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
         end
         kocrt_pkg::ST_RANK: begin
            if (rd_vld_ff && (cnt_rd_ff > hit_cnt_ff) && (rank_ff != kocrt_pkg::RANK_MAX)) begin
               rank_in = rank_ff + 1'b1;
            end
            if (scan_over) begin
               state_in = kocrt_pkg::ST_RESP;
            end else if (issue_ff < used_ff) begin
               issue_in  = issue_ff + 1'b1;
               rd_vld_in = 1'b1;
            end
         end
         kocrt_pkg::ST_RESP: begin
            // hit_* hold only when the scan matched; a miss leaves the flag low
            state_in      = kocrt_pkg::ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_found_in  = 1'b0;
            rsp_occ_in    = '0;
            rsp_rank_in   = '0;
            rsp_status_in = 1'b0;
         end
         default: begin
            state_in = kocrt_pkg::ST_IDLE;
         end
      endcase

      // Resolve the response in the RESP state at the end of the scan: the outcome
      // is taken from the matched flag below.
      if (state_ff == kocrt_pkg::ST_RESP && matched_ff) begin
         rsp_found_in = 1'b1;
         case (req_ff)
            kocrt_pkg::REQ_ADD: begin
               cnt_wr_en  = 1'b1;
               rsp_occ_in = cnt_inc;
            end
            kocrt_pkg::REQ_COUNT: begin
               rsp_occ_in = hit_cnt_ff;
            end
            kocrt_pkg::REQ_RANK: begin
               rsp_occ_in  = hit_cnt_ff;
               rsp_rank_in = rank_ff;
            end
            default: begin
               rsp_found_in = 1'b0;
            end
         endcase
      end else if (state_ff == kocrt_pkg::ST_RESP && req_ff == kocrt_pkg::REQ_ADD) begin
         if (used_ff == FULL_COUNT) begin
            rsp_status_in = 1'b1;
         end else begin
            // append the new key with a count of one
            wr_addr     = used_ff[IDX_W-1:0];
            key_wr_en   = 1'b1;
            cnt_wr_en   = 1'b1;
            cnt_wr_data = kocrt_pkg::COUNT_W'(1);
            used_in     = used_ff + 1'b1;
            rsp_occ_in  = kocrt_pkg::COUNT_W'(1);
         end
      end
   end

   always_comb begin
      matched_in = matched_ff;
      if (state_ff == kocrt_pkg::ST_IDLE) begin
         matched_in = 1'b0;
      end else if (state_ff == kocrt_pkg::ST_SCAN && hit) begin
         matched_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= kocrt_pkg::ST_IDLE;
         used_ff       <= '0;
         rd_vld_ff     <= 1'b0;
         rsp_strobe_ff <= 1'b0;
         matched_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         used_ff       <= used_in;
         rd_vld_ff     <= rd_vld_in;
         rsp_strobe_ff <= rsp_strobe_in;
         matched_ff    <= matched_in;
      end
   end

   always_ff @(posedge clock) begin
      req_ff        <= req_in;
      key_ff        <= key_in;
      issue_ff      <= issue_in;
      hit_idx_ff    <= hit_idx_in;
      hit_cnt_ff    <= hit_cnt_in;
      rank_ff       <= rank_in;
      rsp_found_ff  <= rsp_found_in;
      rsp_occ_ff    <= rsp_occ_in;
      rsp_rank_ff   <= rsp_rank_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign busy            = (state_ff != kocrt_pkg::ST_IDLE);
   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_found       = rsp_found_ff;
   assign rsp_occurrences = rsp_occ_ff;
   assign rsp_rank_value  = rsp_rank_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
